// ===== sv/sorted_table_insert_search_assert.svh =====
// assertion macros used by the sorted table back end
// expects clk_i and rst_ni in the scope of each use
`ifndef SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH
`define SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define STS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sts_pkg.sv =====
// types and codes for the sorted table with insert and binary search
// no dependencies
package sts_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 8;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_SEARCH,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] position;
    logic [CountW-1:0] entries;
    logic              overflow;
  } res_item_t;

  typedef struct packed {
    cmd_kind_e                kind;
    logic signed [ValueW-1:0] value;
  } cmd_t;

endpackage

// ===== sv/sts_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sts_front.sv =====
// front end: takes input beats and turns the op field into a command
// depends on sts_pkg
module sts_front (
  input  logic            start_i,
  input  sts_pkg::in_item_t item_i,
  input  logic            full_i,
  output logic            busy_o,
  output logic            push_o,
  output sts_pkg::cmd_t   cmd_o
);
  import sts_pkg::*;

  cmd_kind_e kind;

  always_comb begin
    unique case (item_i.op)
      OP_INSERT: kind = CMD_INSERT;
      OP_SEARCH: kind = CMD_SEARCH;
      OP_CLEAR:  kind = CMD_CLEAR;
      default:   kind = CMD_NOP;
    endcase
  end

  assign busy_o      = full_i;
  assign push_o      = start_i & ~full_i;
  assign cmd_o.kind  = kind;
  assign cmd_o.value = item_i.value;

endmodule

// ===== sv/sts_cmd_fifo.sv =====
// two-entry command queue between front end and back end
// depends on sts_pkg
module sts_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sts_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output sts_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import sts_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  assign cmd_o   = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

// ===== sv/sts_back.sv =====
// back end: runs insert, binary search and clear against the table ram
// depends on sts_pkg, sts_ram and sorted_table_insert_search_assert.svh
module sts_back #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  sts_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               res_valid_o,
  output sts_pkg::res_item_t res_o
);
  import sts_pkg::*;
  `include "sorted_table_insert_search_assert.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_CMP  = 3'd1;
  localparam logic [2:0] ST_INS_PUT  = 3'd2;
  localparam logic [2:0] ST_SR_PROBE = 3'd3;
  localparam logic [2:0] ST_SR_CMP   = 3'd4;

  logic [2:0]               st_q, st_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            slot_q, slot_d;
  logic [CW-1:0]            lo_q, lo_d;
  logic [CW-1:0]            hi_q, hi_d;
  logic [CW-1:0]            mid_q, mid_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic                     res_valid_q, res_valid_d;
  res_item_t                res_q, res_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;
  logic signed [ValueW-1:0] probe;

  logic [CW-1:0] cnt_m1, cnt_p1, slot_m1, slot_m2, mid_p1;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_w;

  logic in_search;
  logic probing;

  function automatic res_item_t mk_res(logic fnd, logic [CW-1:0] pos, logic [CW-1:0] ent,
                                       logic ovf);
    res_item_t r;
    r.found    = fnd;
    r.position = CountW'(pos);
    r.entries  = CountW'(ent);
    r.overflow = ovf;
    return r;
  endfunction

  assign probe   = $signed(ram_rdata);
  assign cnt_m1  = cnt_q - CW'(1);
  assign cnt_p1  = cnt_q + CW'(1);
  assign slot_m1 = slot_q - CW'(1);
  assign slot_m2 = slot_q - CW'(2);
  assign mid_p1  = mid_q + CW'(1);
  // (first + last) / 2 with last = hi - 1, never negative inside the loop
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
  assign mid_w   = mid_sum[CW:1];

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    val_d       = val_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = slot_q[AW-1:0];
    ram_wdata   = val_q;
    ram_raddr   = mid_w[AW-1:0];

    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          val_d = cmd_i.value;
          unique case (cmd_i.kind)
            CMD_INSERT: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(1'b0, '0, cnt_q, 1'b1);
              end else if (cnt_q == '0) begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = cmd_i.value;
                cnt_d       = cnt_p1;
                res_valid_d = 1'b1;
                res_d       = mk_res(1'b0, '0, cnt_p1, 1'b0);
              end else begin
                ram_raddr = cnt_m1[AW-1:0];
                slot_d    = cnt_q;
                st_d      = ST_INS_CMP;
              end
            end
            CMD_SEARCH: begin
              lo_d = '0;
              hi_d = cnt_q;
              st_d = ST_SR_PROBE;
            end
            CMD_CLEAR: begin
              cnt_d       = '0;
              res_valid_d = 1'b1;
              res_d       = mk_res(1'b0, '0, '0, 1'b0);
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = mk_res(1'b0, '0, cnt_q, 1'b0);
            end
          endcase
        end
      end
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (probe > val_q) begin
          // move the larger entry up one slot and look at the next one down
          ram_wdata = ram_rdata;
          slot_d    = slot_m1;
          ram_raddr = slot_m2[AW-1:0];
          if (slot_m1 == '0) begin
            st_d = ST_INS_PUT;
          end
        end else begin
          cnt_d       = cnt_p1;
          res_valid_d = 1'b1;
          res_d       = mk_res(1'b0, '0, cnt_p1, 1'b0);
          st_d        = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        ram_we      = 1'b1;
        cnt_d       = cnt_p1;
        res_valid_d = 1'b1;
        res_d       = mk_res(1'b0, '0, cnt_p1, 1'b0);
        st_d        = ST_IDLE;
      end
      ST_SR_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d = mid_w;
          st_d  = ST_SR_CMP;
        end else begin
          res_valid_d = 1'b1;
          res_d       = mk_res(1'b0, '0, cnt_q, 1'b0);
          st_d        = ST_IDLE;
        end
      end
      ST_SR_CMP: begin
        st_d = ST_SR_PROBE;
        priority if (probe < val_q) begin
          lo_d = mid_p1;
        end else if (probe == val_q) begin
          res_valid_d = 1'b1;
          res_d       = mk_res(1'b1, mid_p1, cnt_q, 1'b0);
          st_d        = ST_IDLE;
        end else begin
          hi_d = mid_q;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

  sts_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign in_search = (st_q == ST_SR_PROBE) || (st_q == ST_SR_CMP);
  assign probing   = (st_q == ST_SR_PROBE) && (lo_q < hi_q);

  `STS_ASSERT(a_cnt_range, cnt_q <= CW'(CAPACITY), "entry count above capacity")
  `STS_ASSERT(a_cnt_moves_with_result, !$stable(cnt_q) |-> res_valid_q, "count moved silently")
  `STS_ASSERT(a_no_write_in_search, ram_we |-> !in_search, "table written during search")
  `STS_ASSERT_NEXT(a_probe_then_cmp, probing, st_q == ST_SR_CMP && mid_q < hi_q, "bad probe")

endmodule

// ===== sv/sorted_table_insert_search.sv =====
// sorted table of signed values with insert, binary search and clear
// clear, no-op, full-table insert and empty-table insert are answered from idle; other inserts
// move the larger entries up one slot, one per cycle; a search probe is a read and a compare
// state, a hit ends at its compare, a miss at the probe that finds an empty range (8 at most)
// the back end runs one command at a time and is idle again as its result shows, while the
// two-entry queue holds waiting items; reset clears count and queue, not the ram
module sorted_table_insert_search #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  sts_pkg::in_item_t  item_i,
  output logic               busy,
  output logic               result_valid_o,
  output sts_pkg::res_item_t result_o
);
  import sts_pkg::*;

  logic push, pop, q_empty, q_full;
  cmd_t front_cmd, back_cmd;

  sts_front u_front (
    .start_i(start),
    .item_i (item_i),
    .full_i (q_full),
    .busy_o (busy),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  sts_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (back_cmd),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  sts_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(~q_empty),
    .cmd_i      (back_cmd),
    .pop_o      (pop),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

endmodule
